// ----- hw/rtl/rsz_pkg.sv -----
// ----------------------------------------------------------------------------
// rsz_pkg
// Shared widths and codes for the bilinear resize core.
// ----------------------------------------------------------------------------
package rsz_pkg;
    localparam int PIX_W  = 16;
    localparam int FRAC_W = 16;
    localparam int POS_W  = 12;
    localparam int SZ_W   = 10;
    localparam int SCL_W  = 25;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_X_SCALE    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_Y_SCALE    = 3'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;
endpackage

// ----- hw/rtl/rsz_bank.sv -----
// ----------------------------------------------------------------------------
// rsz_bank
// One parity bank of the frame store: one write and one registered read port.
// ----------------------------------------------------------------------------
module rsz_bank
    import rsz_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);
    logic [PIX_W-1:0] r_mem [2**AW];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/bilinear_image_resize_core.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_resize_core
// Frame store in four parity banks with a five-stage bilinear interpolator.
//
//  channel | direction | handshake            | payload
//  in      | sink      | i_valid / o_stall    | i_req_type i_pos_x i_pos_y i_pixel_in
//  out     | source    | o_valid / i_stall    | o_resized_pixel
//  cfg     | sink      | i_cfg_we             | i_cfg_index i_cfg_data
//
// One item per cycle while o_stall is low; only a read request produces a result.
// The four banks (column parity x row parity) deliver all neighbours in one read.
// Reset is synchronous, active low; the store content is not cleared.
// The whole pipeline holds while a result waits and i_stall is high.
// ----------------------------------------------------------------------------
module bilinear_image_resize_core
    import rsz_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [POS_W-1:0]  i_pos_x,
    input  logic [POS_W-1:0]  i_pos_y,
    input  logic [PIX_W-1:0]  i_pixel_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_resized_pixel,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [SCL_W-1:0]  i_cfg_data
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XHW = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
    localparam int YHW = (MAX_HEIGHT > 2) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
    localparam int AW  = XHW + YHW;
    localparam int EW  = 13;
    localparam int SW  = POS_W + SCL_W;
    localparam int IW  = SW - FRAC_W + 1;

    logic [SZ_W-1:0]  r_src_w, r_src_h;
    logic [SCL_W-1:0] r_xs, r_ys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SZ_W'(512);
            r_src_h <= SZ_W'(512);
            r_xs    <= SCL_W'(65536);
            r_ys    <= SCL_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SZ_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SZ_W-1:0];
                CFG_X_SCALE:    r_xs    <= i_cfg_data;
                CFG_Y_SCALE:    r_ys    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [EW-1:0] w_eff, h_eff;
    assign w_eff = (r_src_w == '0) ? EW'(1) :
                   ((EW'(r_src_w) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(r_src_w));
    assign h_eff = (r_src_h == '0) ? EW'(1) :
                   ((EW'(r_src_h) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(r_src_h));

    logic advance;
    assign advance = !o_valid || !i_stall;
    assign o_stall = !advance;

    // stage 1: captured item
    logic             r_v1, r_rq1;
    logic [POS_W-1:0] r_px1, r_py1;
    logic [PIX_W-1:0] r_pix1;
    // stage 2: scaled coordinates
    logic             r_v2, r_rq2;
    logic [SW-1:0]    r_sx, r_sy;
    logic [POS_W-1:0] r_px2, r_py2;
    logic [PIX_W-1:0] r_pix2;
    // stage 3: bank data
    logic              r_v3;
    logic [FRAC_W-1:0] r_fx3, r_fy3;
    logic              r_xs3, r_xd3, r_ys3, r_yd3;
    // stage 4: row products
    logic              r_v4;
    logic [PIX_W-1:0]  r_a0, r_a1;
    logic signed [2*PIX_W+1:0] r_d0, r_d1;
    logic [FRAC_W-1:0] r_fy4;
    // stage 5: column product
    logic              r_v5;
    logic [PIX_W-1:0]  r_r0;
    logic signed [2*PIX_W+1:0] r_dr;
    // output
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_data;

    // stage 2 combinational: clamp and bank addressing
    logic [IW-1:0] ix, iy, ix1, iy1;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [XW-1:0] wx;
    logic [YW-1:0] wy;
    logic          wr_ok;

    assign ix  = IW'(r_sx[SW-1:FRAC_W]);
    assign iy  = IW'(r_sy[SW-1:FRAC_W]);
    assign ix1 = ix + IW'(1);
    assign iy1 = iy + IW'(1);
    assign x0 = (ix  >= IW'(w_eff)) ? XW'(w_eff - EW'(1)) : XW'(ix);
    assign x1 = (ix1 >= IW'(w_eff)) ? XW'(w_eff - EW'(1)) : XW'(ix1);
    assign y0 = (iy  >= IW'(h_eff)) ? YW'(h_eff - EW'(1)) : YW'(iy);
    assign y1 = (iy1 >= IW'(h_eff)) ? YW'(h_eff - EW'(1)) : YW'(iy1);

    assign wr_ok = (EW'(r_px2) < w_eff) && (EW'(r_py2) < h_eff);
    assign wx = XW'(r_px2);
    assign wy = YW'(r_py2);

    logic [PIX_W-1:0] q [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = b[0];
        localparam logic BY = b[1];
        logic [XW-1:0] cx;
        logic [YW-1:0] cy;
        logic          we;
        assign cx = (x0[0] == BX) ? x0 : x1;
        assign cy = (y0[0] == BY) ? y0 : y1;
        assign we = advance && r_v2 && (r_rq2 == REQ_WRITE) && wr_ok &&
                    (wx[0] == BX) && (wy[0] == BY);
        rsz_bank #(.AW(AW)) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr ({YHW'(wy >> 1), XHW'(wx >> 1)}),
            .i_wdata (r_pix2),
            .i_re    (advance && r_v2 && (r_rq2 == REQ_READ)),
            .i_raddr ({YHW'(cy >> 1), XHW'(cx >> 1)}),
            .o_rdata (q[b])
        );
    end

    // stage 3 combinational: pick neighbours, horizontal differences
    logic [PIX_W-1:0] p00, p01, p10, p11;
    logic signed [PIX_W:0] dh0, dh1;
    assign p00 = q[{r_ys3, r_xs3}];
    assign p01 = q[{r_ys3, r_xd3}];
    assign p10 = q[{r_yd3, r_xs3}];
    assign p11 = q[{r_yd3, r_xd3}];
    assign dh0 = $signed({1'b0, p01}) - $signed({1'b0, p00});
    assign dh1 = $signed({1'b0, p11}) - $signed({1'b0, p10});

    // stage 4 combinational: row values
    logic signed [PIX_W+2:0] s0, s1;
    logic [PIX_W-1:0]        rv0, rv1;
    logic signed [PIX_W:0]   dv;
    assign s0  = $signed({3'b000, r_a0}) + (PIX_W+3)'(r_d0 >>> FRAC_W);
    assign s1  = $signed({3'b000, r_a1}) + (PIX_W+3)'(r_d1 >>> FRAC_W);
    assign rv0 = s0[PIX_W-1:0];
    assign rv1 = s1[PIX_W-1:0];
    assign dv  = $signed({1'b0, rv1}) - $signed({1'b0, rv0});

    logic signed [PIX_W+2:0] s2;
    assign s2 = $signed({3'b000, r_r0}) + (PIX_W+3)'(r_dr >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2 && (r_rq2 == REQ_READ);
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rq1  <= i_req_type;
            r_px1  <= i_pos_x;
            r_py1  <= i_pos_y;
            r_pix1 <= i_pixel_in;

            r_rq2  <= r_rq1;
            r_sx   <= SW'(r_px1) * SW'(r_xs);
            r_sy   <= SW'(r_py1) * SW'(r_ys);
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_pix2 <= r_pix1;

            r_fx3 <= r_sx[FRAC_W-1:0];
            r_fy3 <= r_sy[FRAC_W-1:0];
            r_xs3 <= x0[0];
            r_xd3 <= x1[0];
            r_ys3 <= y0[0];
            r_yd3 <= y1[0];

            r_a0  <= p00;
            r_a1  <= p10;
            r_d0  <= (2*PIX_W+2)'(dh0 * $signed({1'b0, r_fx3}));
            r_d1  <= (2*PIX_W+2)'(dh1 * $signed({1'b0, r_fx3}));
            r_fy4 <= r_fy3;

            r_r0 <= rv0;
            r_dr <= (2*PIX_W+2)'(dv * $signed({1'b0, r_fy4}));

            r_out_data <= s2[PIX_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_resized_pixel = r_out_data;

    a_x_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_rq2 == REQ_READ) |-> (x1 == x0 || x1 == x0 + XW'(1)))
        else $error("column neighbour not adjacent");
    a_y_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_rq2 == REQ_READ) |-> (y1 == y0 || y1 == y0 + YW'(1)))
        else $error("row neighbour not adjacent");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance) |=> ($stable(r_v5) && $stable(r_v3) && $stable(r_out_data)))
        else $error("pipeline moved while held");
    a_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_v2 && r_rq2 == REQ_WRITE) |=> !r_v3)
        else $error("write produced a result slot");
endmodule
